// ===== rtl/lpht_pkg.sv =====
`default_nettype none
package lpht_pkg;

  localparam int KeyWordW = 16;
  localparam int NumKeyWords = 8;
  localparam logic [31:0] HashMult = 32'd1664525;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_ABSENT   = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_CLEAR, S_SLOT_RD, S_SLOT_CHK, S_KEY_RD, S_KEY_CHK,
    S_INS, S_RD_RD, S_RD_CHK, S_OUT
  } state_t;

  localparam logic [1:0] CfgKeyWords = 2'd0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic signed [15:0] key_0;
    logic signed [15:0] key_1;
    logic signed [15:0] key_2;
    logic signed [15:0] key_3;
    logic signed [15:0] key_4;
    logic signed [15:0] key_5;
    logic signed [15:0] key_6;
    logic signed [15:0] key_7;
    logic [8:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  entry_id;
    logic [9:0]  entry_count;
    logic signed [15:0] out_word_0;
    logic signed [15:0] out_word_1;
    logic signed [15:0] out_word_2;
    logic signed [15:0] out_word_3;
    logic signed [15:0] out_word_4;
    logic signed [15:0] out_word_5;
    logic signed [15:0] out_word_6;
    logic signed [15:0] out_word_7;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic hash_init;  // clear hash and word counter
    logic hash_step;  // one multiply-accumulate
    logic clr_init;   // start clearing sweep
    logic clr_step;
    logic slot_rd;    // read slot at probe index, restart word counter
    logic key_rd;     // read stored key of slot's id / word counter
    logic word_adv;   // next key word
    logic probe_adv;  // next slot
    logic key_wr;     // write one key word of the new entry
    logic do_insert;  // write slot and bump count
    logic set_found;
    logic set_absent;
    logic set_full;
    logic set_done;
    logic rd_init;
    logic rd_capture; // store read word into output
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_last;  // last word of hash
    logic clr_last;
    logic slot_valid;
    logic key_eq;
    logic word_last;
    logic ins_last;   // last key word written
    logic is_full;
    logic rd_ok;      // entry index below count
  } dp_stat_t;

  function automatic logic [3:0] eff_words(input logic [3:0] kw);
    if (kw == 4'd0) return 4'd1;
    if (kw > 4'(NumKeyWords)) return 4'(NumKeyWords);
    return kw;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lpht_datapath.sv =====
`default_nettype none
module lpht_datapath
  import lpht_pkg::*;
#(
  parameter int SLOT_COUNT = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_data,
  input  wire logic [3:0] key_words,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  output out_word_t      result
);
  localparam int SlotW  = $clog2(SLOT_COUNT);
  localparam int Limit  = SLOT_COUNT / 2;
  localparam int IdW    = (Limit > 1) ? $clog2(Limit) : 1;
  localparam int CntW   = $clog2(Limit + 1);

  // slot memory: valid bit plus id; cleared by a sweep
  logic [IdW:0]        slot_mem [SLOT_COUNT];
  logic [KeyWordW-1:0] key_mem  [Limit*NumKeyWords];

  in_word_t            item_r;
  logic [15:0]         words [NumKeyWords];
  logic [31:0]         hash_r, hash_nxt;
  logic [2:0]          widx_r;
  logic [SlotW-1:0]    probe_r, clr_r;
  logic [IdW:0]        slot_q_r;
  logic [KeyWordW-1:0] key_q_r;
  logic [CntW-1:0]     count_r;
  out_word_t           res_r;
  logic [3:0]          n_eff;
  logic [31:0]         acc;
  logic [IdW-1:0]      slot_id;

  assign words[0] = item_r.key_0;
  assign words[1] = item_r.key_1;
  assign words[2] = item_r.key_2;
  assign words[3] = item_r.key_3;
  assign words[4] = item_r.key_4;
  assign words[5] = item_r.key_5;
  assign words[6] = item_r.key_6;
  assign words[7] = item_r.key_7;

  assign n_eff = eff_words(key_words);
  assign acc = hash_r + {{16{words[widx_r][15]}}, words[widx_r]};
  assign hash_nxt = acc * HashMult;

  assign slot_id = slot_q_r[IdW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.hash_init) begin
      hash_r <= '0;
      widx_r <= '0;
    end else if (cmd.hash_step) begin
      hash_r <= hash_nxt;
      widx_r <= widx_r + 3'd1;
    end else if (cmd.word_adv || cmd.rd_capture || cmd.key_wr) begin
      widx_r <= widx_r + 3'd1;
    end else if (cmd.slot_rd || cmd.rd_init) begin
      widx_r <= '0;
    end
    if (!rst_n || cmd.clr_init) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
    if (cmd.slot_rd) slot_q_r <= slot_mem[probe_r];
    if (cmd.key_rd) key_q_r <= key_mem[{slot_id, widx_r}];
    if (cmd.rd_init) key_q_r <= key_mem[{item_r.entry_index[IdW-1:0], 3'd0}];
    if (cmd.rd_capture) key_q_r <= key_mem[{item_r.entry_index[IdW-1:0], widx_r + 3'd1}];
  end

  // probe index: start at hash, advance with wrap
  always_ff @(posedge clk) begin
    if (cmd.hash_step && widx_r == 3'(n_eff - 4'd1)) probe_r <= hash_nxt[SlotW-1:0];
    else if (cmd.probe_adv) probe_r <= probe_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) slot_mem[clr_r] <= '0;
    else if (cmd.do_insert) slot_mem[probe_r] <= {1'b1, count_r[IdW-1:0]};
  end

  // key store takes one word a cycle while an entry is inserted
  always_ff @(posedge clk) begin
    if (cmd.key_wr) key_mem[{count_r[IdW-1:0], widx_r}] <= words[widx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd.clr_init) count_r <= '0;
    else if (cmd.do_insert) count_r <= count_r + 1'b1;
  end

  assign stat.hash_last  = (widx_r == 3'(n_eff - 4'd1));
  assign stat.clr_last   = (clr_r == SlotW'(SLOT_COUNT - 1));
  assign stat.slot_valid = slot_q_r[IdW];
  assign stat.key_eq     = (key_q_r == words[widx_r]);
  assign stat.word_last  = (widx_r == 3'(n_eff - 4'd1));
  assign stat.ins_last   = (widx_r == 3'(NumKeyWords - 1));
  assign stat.is_full    = (count_r >= CntW'(Limit));
  assign stat.rd_ok      = ({1'b0, item_r.entry_index} < 10'(count_r));

  always_ff @(posedge clk) begin
    if (cmd.load) res_r <= '0;
    if (cmd.set_found) begin
      res_r.status <= ST_FOUND;
      res_r.entry_id <= 9'(slot_id);
    end
    if (cmd.set_absent) res_r.status <= ST_ABSENT;
    if (cmd.set_full) res_r.status <= ST_FULL;
    if (cmd.set_done) res_r.status <= ST_DONE;
    if (cmd.do_insert) begin
      res_r.status <= ST_INSERTED;
      res_r.entry_id <= 9'(count_r);
    end
    if (cmd.rd_capture) begin
      unique case (widx_r)
        3'd0: res_r.out_word_0 <= key_q_r;
        3'd1: res_r.out_word_1 <= key_q_r;
        3'd2: res_r.out_word_2 <= key_q_r;
        3'd3: res_r.out_word_3 <= key_q_r;
        3'd4: res_r.out_word_4 <= key_q_r;
        3'd5: res_r.out_word_5 <= key_q_r;
        3'd6: res_r.out_word_6 <= key_q_r;
        default: res_r.out_word_7 <= key_q_r;
      endcase
    end
  end

  always_comb begin
    result = res_r;
    result.entry_count = 10'(count_r);
  end
endmodule
`default_nettype wire

// ===== rtl/lpht_ctrl.sv =====
`default_nettype none
module lpht_ctrl
  import lpht_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [1:0] in_op,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);
  state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      op_r <= OP_LOOKUP;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_INIT: begin
        // empty every slot once after reset
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.hash_init = 1'b1;
          op_nxt = in_op;
          unique case (in_op)
            OP_CLEAR: begin
              cmd.clr_init = 1'b1;
              state_nxt = S_CLEAR;
            end
            OP_READ: state_nxt = S_RD_RD;
            default: state_nxt = S_HASH;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.set_done = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_last) state_nxt = S_SLOT_RD;
      end
      S_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        if (!stat.slot_valid) begin
          if (op_r == OP_INSERT) begin
            if (stat.is_full) begin
              cmd.set_full = 1'b1;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_INS;
            end
          end else begin
            cmd.set_absent = 1'b1;
            state_nxt = S_OUT;
          end
        end else begin
          cmd.key_rd = 1'b1;
          state_nxt = S_KEY_CHK;
        end
      end
      S_KEY_CHK: begin
        if (!stat.key_eq) begin
          // mismatch: move on to the next slot
          cmd.probe_adv = 1'b1;
          state_nxt = S_SLOT_RD;
        end else if (stat.word_last) begin
          cmd.set_found = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.word_adv = 1'b1;
          state_nxt = S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        cmd.key_rd = 1'b1;
        state_nxt = S_KEY_CHK;
      end
      S_INS: begin
        cmd.key_wr = 1'b1;
        if (stat.ins_last) begin
          cmd.do_insert = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_RD_RD: begin
        cmd.rd_init = 1'b1;
        if (stat.rd_ok) state_nxt = S_RD_CHK;
        else begin
          cmd.set_absent = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_RD_CHK: begin
        cmd.rd_capture = 1'b1;
        if (stat.word_last) begin
          cmd.set_done = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
`default_nettype none
// Open-addressing hash table, linear probing. One result word per input word.
// After reset the slot memory is swept empty with in_ready low.
// Lookup/insert: accept, hash the key words in use (one multiply each), then read
// and check the probed slot, comparing an occupied slot's stored key word by word;
// an insert then writes all eight key words into the key store one word a cycle.
// Read: accept, index check, then capture of the key words (none when the id is
// unused). Clear: accept, then a sweep over all SLOT_COUNT slots. Each result then
// stays on out_valid while out_ready is low, and the next word is accepted only after
// it has left.
// Insert is refused with full status once half the slots hold entries.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int SLOT_COUNT = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_psel,
  input  wire logic      cfg_penable,
  input  wire logic      cfg_pwrite,
  input  wire logic      cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);
  logic [3:0] key_words_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [1:0] addr_idx;

  assign cfg_pready = 1'b1;
  assign addr_idx = {1'b0, cfg_paddr};
  assign cfg_prdata = (addr_idx == CfgKeyWords) ? {28'd0, key_words_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) key_words_r <= 4'd4;
    else if (cfg_psel && cfg_penable && cfg_pwrite && addr_idx == CfgKeyWords)
      key_words_r <= cfg_pwdata[3:0];
  end

  lpht_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_op(in_data.opcode),
    .out_valid, .out_ready, .stat, .cmd
  );

  lpht_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk, .rst_n, .in_data, .key_words(key_words_r), .cmd, .stat, .result(out_data)
  );
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import lpht_pkg::*;

  localparam int Slots = 1024;
  localparam int EntryMax = Slots / 2;
  localparam int IdleLimit = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_word_t in_data;
  out_word_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pready;
  logic [31:0] cfg_pwdata, cfg_prdata;

  linear_probe_hash_table #(.SLOT_COUNT(Slots)) uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata,
    .cfg_pready
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow table state
  bit          shd_valid[Slots];
  logic [8:0]  shd_id[Slots];
  logic [15:0] shd_keys[EntryMax][NumKeyWords];
  int          shd_fill;
  logic [3:0]  shd_kw;

  out_word_t result_q[$];
  int err_cnt, n_items, n_results, n_found, n_ins, n_full, n_cfg;
  int burst_left;
  bit hold_req;
  int hold_cnt, ready_phase;
  int idle_cycles;

  function automatic logic [15:0] key_at(in_word_t w, int i);
    logic [127:0] k;
    k = w[136:9];
    return k[16*(7-i) +: 16];
  endfunction

  function automatic logic [15:0] oword_at(out_word_t o, int i);
    logic [127:0] k;
    k = o[127:0];
    return k[16*(7-i) +: 16];
  endfunction

  function automatic out_word_t predict_table_op(in_word_t w);
    out_word_t r;
    logic [127:0] ow;
    int n, e, probes;
    logic [31:0] h;
    logic [9:0] slot;
    logic [15:0] kv;
    bit eq;
    r = '0;
    ow = '0;
    n = (shd_kw == 0) ? 1 : (shd_kw > NumKeyWords) ? NumKeyWords : shd_kw;
    r.status = ST_ABSENT;
    case (opcode_t'(w.opcode))
      OP_CLEAR: begin
        for (int s = 0; s < Slots; s++) shd_valid[s] = 1'b0;
        shd_fill = 0;
        r.status = ST_DONE;
      end
      OP_READ: begin
        e = w.entry_index;
        if (e < shd_fill) begin
          for (int i = 0; i < n; i++) ow[16*(7-i) +: 16] = shd_keys[e][i];
          r.status = ST_DONE;
        end
      end
      default: begin
        h = '0;
        for (int i = 0; i < n; i++) begin
          kv = key_at(w, i);
          h = (h + {{16{kv[15]}}, kv}) * 32'd1664525;
        end
        slot = h[9:0];
        for (probes = 0; probes < Slots; probes++) begin
          if (!shd_valid[slot]) begin
            if (opcode_t'(w.opcode) == OP_INSERT) begin
              if (2 * shd_fill >= Slots) r.status = ST_FULL;
              else begin
                for (int i = 0; i < NumKeyWords; i++) shd_keys[shd_fill][i] = key_at(w, i);
                shd_valid[slot] = 1'b1;
                shd_id[slot] = shd_fill[8:0];
                r.entry_id = shd_fill[8:0];
                shd_fill++;
                r.status = ST_INSERTED;
              end
            end
            break;
          end
          eq = 1'b1;
          for (int i = 0; i < n; i++)
            if (shd_keys[shd_id[slot]][i] != key_at(w, i)) eq = 1'b0;
          if (eq) begin
            r.entry_id = shd_id[slot];
            r.status = ST_FOUND;
            break;
          end
          slot = slot + 10'd1;
        end
      end
    endcase
    r.entry_count = shd_fill[9:0];
    r[127:0] = ow;
    return r;
  endfunction

  task automatic report(string what, logic [15:0] exp_v, logic [15:0] got_v);
    $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, exp_v, got_v);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t ex;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word %0h", $time, out_data);
        err_cnt++;
      end else begin
        ex = result_q.pop_front();
        if (out_data.status !== ex.status)
          report("status", 16'(ex.status), 16'(out_data.status));
        if (out_data.entry_id !== ex.entry_id)
          report("entry_id", 16'(ex.entry_id), 16'(out_data.entry_id));
        if (out_data.entry_count !== ex.entry_count)
          report("entry_count", 16'(ex.entry_count), 16'(out_data.entry_count));
        for (int i = 0; i < NumKeyWords; i++)
          if (oword_at(out_data, i) !== oword_at(ex, i))
            report($sformatf("out_word_%0d", i), oword_at(ex, i), oword_at(out_data, i));
      end
    end
  end

  // receiver: alternate free-running and choppy stretches, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_cnt <= 400;
      hold_req <= 1'b0;
    end else begin
      ready_phase <= ready_phase + 1;
      out_ready <= (ready_phase[6]) ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, no progress", $time);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
    int gap;
    out_word_t p;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    p = predict_table_op(w);
    result_q.push_back(typed ? typed_res : p);
    n_items++;
    if (p.status == ST_FOUND) n_found++;
    if (p.status == ST_INSERTED) n_ins++;
    if (p.status == ST_FULL) n_full++;
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key_words(logic [3:0] v);
    drain();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CfgKeyWords[0];
    cfg_pwdata <= {28'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shd_kw = v;
    n_cfg++;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  logic [127:0] key_pool[16];

  function automatic in_word_t make_word(opcode_t op, logic [127:0] k, logic [8:0] idx);
    in_word_t w;
    w.opcode = op;
    w[136:9] = k;
    w.entry_index = idx;
    return w;
  endfunction

  function automatic logic [127:0] rand_key();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  task automatic random_items(int count, int ins_pct, bit fresh_heavy);
    opcode_t op;
    logic [127:0] k;
    logic [8:0] idx;
    int r;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(0, 99);
      op = (r < 2) ? OP_CLEAR : (r < 2 + ins_pct) ? OP_INSERT :
           (r < 12 + ins_pct) ? OP_READ : OP_LOOKUP;
      if (fresh_heavy ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 2) == 0))
        k = rand_key();
      else begin
        k = key_pool[$urandom_range(0, 15)];
        // perturb words that may lie beyond the compared length
        if ($urandom_range(0, 3) == 0) k[15:0] = 16'($urandom());
      end
      idx = $urandom_range(0, 1) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, shd_fill + 2));
      send_word(make_word(op, k, idx), 1'b0, '0);
    end
  endtask

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(opcode_t op, logic [127:0] k, logic [8:0] idx, bit typed,
                         status_t st, logic [8:0] id, logic [9:0] cnt);
    dir_row_t d;
    d.w = make_word(op, k, idx);
    d.typed = typed;
    d.res = '0;
    d.res.status = st;
    d.res.entry_id = id;
    d.res.entry_count = cnt;
    dir_rows.push_back(d);
  endtask

  initial begin
    logic [127:0] kmax, kmin;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 1'b0;
    cfg_pwdata = '0;
    hold_req = 1'b0;
    hold_cnt = 0;
    ready_phase = 0;
    idle_cycles = 0;
    burst_left = 0;
    for (int s = 0; s < Slots; s++) shd_valid[s] = 1'b0;
    shd_fill = 0;
    shd_kw = 4'd4;
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    kmax = {8{16'h7fff}};
    kmin = {8{16'h8000}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(OP_LOOKUP, kmax, 9'd0, 1'b1, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_READ, '0, 9'd0, 1'b1, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_READ, '1, 9'd511, 1'b1, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_INSERT, kmax, 9'd0, 1'b1, ST_INSERTED, 9'd0, 10'd1);
    add_row(OP_INSERT, kmin, 9'd0, 1'b1, ST_INSERTED, 9'd1, 10'd2);
    add_row(OP_INSERT, kmax, 9'd0, 1'b1, ST_FOUND, 9'd0, 10'd2);
    add_row(OP_LOOKUP, kmin, 9'd0, 1'b1, ST_FOUND, 9'd1, 10'd2);
    add_row(OP_INSERT, '0, 9'd0, 1'b0, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_INSERT, '1, 9'd0, 1'b0, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_READ, '0, 9'd0, 1'b0, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_READ, '0, 9'd1, 1'b0, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_READ, '0, 9'd3, 1'b0, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_READ, '0, 9'd4, 1'b1, ST_ABSENT, 9'd0, 10'd4);
    // same leading words, different tail: found when only four words compare
    add_row(OP_LOOKUP, {kmax[127:64], 64'h0123_4567_89ab_cdef}, 9'd0, 1'b1,
            ST_FOUND, 9'd0, 10'd4);
    add_row(OP_LOOKUP, {16'h1234, 112'd0}, 9'd0, 1'b1, ST_ABSENT, 9'd0, 10'd4);
    add_row(OP_CLEAR, kmax, 9'd0, 1'b1, ST_DONE, 9'd0, 10'd0);
    add_row(OP_LOOKUP, kmax, 9'd0, 1'b1, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_READ, '0, 9'd0, 1'b1, ST_ABSENT, 9'd0, 10'd0);
    add_row(OP_INSERT, kmin, 9'd0, 1'b1, ST_INSERTED, 9'd0, 10'd1);
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    write_key_words(4'd0);
    random_items(25, 30, 1'b0);
    write_key_words(4'd1);
    random_items(25, 30, 1'b0);
    write_key_words(4'd8);
    random_items(25, 30, 1'b0);
    write_key_words(4'd15);
    random_items(20, 30, 1'b0);
    write_key_words(4'd3);
    random_items(20, 30, 1'b0);

    // fill to the half-load limit, with the receiver held off part way through
    write_key_words(4'd8);
    send_word(make_word(OP_CLEAR, '0, 9'd0), 1'b0, '0);
    for (int j = 0; j < 600; j++) begin
      if (j == 100) hold_req = 1'b1;
      send_word(make_word(($urandom_range(0, 19) != 0) ? OP_INSERT :
                          ($urandom_range(0, 1) ? OP_READ : OP_LOOKUP),
                          ($urandom_range(0, 19) == 0) ? key_pool[$urandom_range(0, 15)]
                                                        : rand_key(),
                          9'($urandom_range(0, 511))), 1'b0, '0);
    end
    write_key_words(4'd2);
    random_items(15, 20, 1'b0);

    drain();
    repeat (1100) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, result_q.size());
      err_cnt++;
    end
    $display("Ran %0d words through the table, %0d results, %0d key_words writes",
             n_items, n_results, n_cfg);
    $display("  %0d hits, %0d inserts, %0d refused as full", n_found, n_ins, n_full);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
